// File: sv/sobel_pkg.sv
package sobel_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int GRAD_W    = PIX_W + 3;
    localparam int MAG_W     = 23;

    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_WIDTH_DEF  = 1024;

    localparam logic [CFG_W-1:0] FRAME_RESET = CFG_W'(1024);
    localparam int               THR_RESET   = 128;
    localparam logic [MAG_W-1:0] THR_SQ_RESET = MAG_W'((THR_RESET + 1) * (THR_RESET + 1));

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;

    // Index 0 is column x-2, index 1 column x-1, index 2 column x.
    typedef logic [2:0][PIX_W-1:0] pix_row_t;

    // Kernel input: [row][column], rows and columns in ascending order.
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef struct packed {
        pix_t older;
        pix_t prev;
    } col_pair_t;

endpackage

// File: sv/sobel_col_buf.sv
module sobel_col_buf
    import sobel_pkg::*;
#(
    parameter int DEPTH = MAX_HEIGHT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output col_pair_t     rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  col_pair_t     wr_data
);

    col_pair_t mem [DEPTH];
    col_pair_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/sobel_row_cell.sv
module sobel_row_cell
    import sobel_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     shift_en,
    input  pix_row_t row_in,
    output pix_row_t row_out
);

    pix_row_t row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else if (shift_en) begin
            row_reg <= row_in;
        end
    end

    assign row_out = row_reg;

endmodule

// File: sv/sobel_grad.sv
module sobel_grad
    import sobel_pkg::*;
(
    input  win_t                     win,
    output logic signed [GRAD_W-1:0] gx,
    output logic signed [GRAD_W-1:0] gy
);

    logic [PIX_W+1:0] right_sum;
    logic [PIX_W+1:0] left_sum;
    logic [PIX_W+1:0] bottom_sum;
    logic [PIX_W+1:0] top_sum;

    assign right_sum  = {2'b00, win[0][2]} + {1'b0, win[1][2], 1'b0} + {2'b00, win[2][2]};
    assign left_sum   = {2'b00, win[0][0]} + {1'b0, win[1][0], 1'b0} + {2'b00, win[2][0]};
    assign bottom_sum = {2'b00, win[2][0]} + {1'b0, win[2][1], 1'b0} + {2'b00, win[2][2]};
    assign top_sum    = {2'b00, win[0][0]} + {1'b0, win[0][1], 1'b0} + {2'b00, win[0][2]};

    assign gx = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    assign gy = $signed({1'b0, bottom_sum}) - $signed({1'b0, top_sum});

endmodule

// File: sv/sobel_mag.sv
module sobel_mag
    import sobel_pkg::*;
(
    input  logic signed [GRAD_W-1:0] gx,
    input  logic signed [GRAD_W-1:0] gy,
    input  logic [MAG_W-1:0]         thr_sq,
    output logic                     edge_bit
);

    logic signed [2*GRAD_W-1:0] sq_x;
    logic signed [2*GRAD_W-1:0] sq_y;
    logic [MAG_W-1:0]           mag2;

    assign sq_x = gx * gx;
    assign sq_y = gy * gy;
    assign mag2 = MAG_W'($unsigned(sq_x)) + MAG_W'($unsigned(sq_y));
    assign edge_bit = (mag2 >= thr_sq);

endmodule

// File: sv/sobel_edge_threshold.sv
// Pipeline: input register, window cells, gradient registers, output register.
// Throughput: one pixel per cycle while m_ready holds; a pixel that completes the last row
// or the last column yields two results (four at the frame corner), one per cycle through
// the single output register, and stalls the input until its last result is taken.
// Reset: counters, pipeline valid flags and the window clear, registers take their
// reset values; the column memories are not cleared and need no clearing pass.
module sobel_edge_threshold
    import sobel_pkg::*;
#(
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_gray_level,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COORD_W-1:0]   m_pixel_x,
    output logic [COORD_W-1:0]   m_pixel_y,
    output logic                 m_edge_bit,
    output logic                 m_run_last
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int XSZW = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
    localparam int YSZW = (YW + 1 > CFG_W) ? YW + 1 : CFG_W;

    typedef struct packed {
        logic               res;
        logic               ytop;
        logic               xleft;
        logic               ylast;
        logic               xlast;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
    } item_t;

    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [MAG_W-1:0] thr_sq_reg, thr_sq_next;
    logic [CFG_W:0]   lim_w;
    logic [2*(CFG_W+1)-1:0] lim_sq_w;
    logic             cfg_we;
    logic             size_write;

    logic [XSZW-1:0]  w_ext;
    logic [YSZW-1:0]  h_ext;
    logic [XW-1:0]    wm1;
    logic [YW-1:0]    hm1;
    logic [XW-1:0]    x_reg, x_next;
    logic [YW-1:0]    y_reg, y_next;

    logic             accept;
    logic             rdy1, rdy2, rdy3, en4;
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    item_t            item_in, item1_reg, item2_reg, item3_reg;
    pix_t             g1_reg;
    logic [YW-1:0]    yaddr1_reg;
    col_pair_t        rd_pair;
    col_pair_t        wr_pair;
    logic             win_shift;

    pix_row_t         new_row;
    pix_row_t         cell_in  [3];
    pix_row_t         win_row  [3];
    pix_row_t         rset     [2][3];
    win_t             sel      [4];

    logic signed [GRAD_W-1:0] gx_w [4];
    logic signed [GRAD_W-1:0] gy_w [4];
    logic signed [GRAD_W-1:0] gx3_reg [4];
    logic signed [GRAD_W-1:0] gy3_reg [4];
    logic                     bit_w [4];

    logic [COORD_W-1:0] ex_reg [4], ex_next [4];
    logic [COORD_W-1:0] ey_reg [4], ey_next [4];
    logic               eb_reg [4], eb_next [4];
    logic [1:0]         last_reg, last_next;
    logic [1:0]         idx_reg;
    logic [COORD_W-1:0] x1_w, y1_w;

    // Configuration registers.
    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid && cfg_ready;
    assign size_write = cfg_we &&
                        (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
    assign lim_w      = (CFG_W+1)'(cfg_data) + (CFG_W+1)'(1);
    assign lim_sq_w   = lim_w * lim_w;

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        thr_sq_next       = thr_sq_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:    frame_width_next  = cfg_data;
                REG_FRAME_HEIGHT:   frame_height_next = cfg_data;
                REG_EDGE_THRESHOLD: thr_sq_next       = MAG_W'(lim_sq_w);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_RESET;
            frame_height_reg <= FRAME_RESET;
            thr_sq_reg       <= THR_SQ_RESET;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            thr_sq_reg       <= thr_sq_next;
        end
    end

    // Effective frame size, clamped to the supported range.
    assign w_ext = XSZW'(frame_width_reg);
    assign h_ext = YSZW'(frame_height_reg);

    always_comb begin
        priority if (w_ext < XSZW'(2)) begin
            wm1 = XW'(1);
        end else if (w_ext > XSZW'(MAX_WIDTH)) begin
            wm1 = XW'(MAX_WIDTH - 1);
        end else begin
            wm1 = XW'(w_ext - XSZW'(1));
        end
        priority if (h_ext < YSZW'(2)) begin
            hm1 = YW'(1);
        end else if (h_ext > YSZW'(MAX_HEIGHT)) begin
            hm1 = YW'(MAX_HEIGHT - 1);
        end else begin
            hm1 = YW'(h_ext - YSZW'(1));
        end
    end

    // Scan position.
    assign accept = s_valid && s_ready;

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        priority if (size_write) begin
            x_next = '0;
            y_next = '0;
        end else if (accept) begin
            if (y_reg == hm1) begin
                y_next = '0;
                x_next = (x_reg == wm1) ? '0 : x_reg + XW'(1);
            end else begin
                y_next = y_reg + YW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            y_reg <= '0;
        end else begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    always_comb begin
        item_in.res   = (x_reg != '0) && (y_reg != '0);
        item_in.ytop  = (y_reg == YW'(1));
        item_in.xleft = (x_reg == XW'(1));
        item_in.ylast = (y_reg == hm1);
        item_in.xlast = (x_reg == wm1);
        item_in.x0    = COORD_W'(x_reg - XW'(1));
        item_in.y0    = COORD_W'(y_reg - YW'(1));
    end

    // Pipeline flow control.
    assign en4     = !v4_reg || (m_ready && idx_reg == last_reg);
    assign rdy3    = !v3_reg || en4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= accept;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            g1_reg     <= s_gray_level;
            yaddr1_reg <= y_reg;
            item1_reg  <= item_in;
        end
        if (rdy2) begin
            item2_reg <= item1_reg;
        end
        if (rdy3) begin
            item3_reg <= item2_reg;
            gx3_reg   <= gx_w;
            gy3_reg   <= gy_w;
        end
    end

    // Two previous columns, one entry per row.
    assign win_shift = v1_reg && rdy2;
    assign wr_pair   = '{older: rd_pair.prev, prev: g1_reg};

    sobel_col_buf #(
        .DEPTH (MAX_HEIGHT)
    ) u_col_buf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (y_reg),
        .rd_data (rd_pair),
        .wr_en   (win_shift),
        .wr_addr (yaddr1_reg),
        .wr_data (wr_pair)
    );

    // Window rows y-2, y-1, y as a chain of cells; the newest row enters at the bottom, cell 2.
    assign new_row    = {g1_reg, rd_pair.prev, rd_pair.older};
    assign cell_in[2] = new_row;

    for (genvar k = 0; k < 3; k++) begin : g_cell
        if (k < 2) begin : g_link
            assign cell_in[k] = win_row[k+1];
        end
        sobel_row_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (win_shift),
            .row_in   (cell_in[k]),
            .row_out  (win_row[k])
        );
    end

    // Mirrored neighborhoods for the pixel one row and one column back, and for
    // the last row and last column.
    always_comb begin
        rset[0][0] = item2_reg.ytop ? win_row[2] : win_row[0];
        rset[0][1] = win_row[1];
        rset[0][2] = win_row[2];
        rset[1][0] = win_row[1];
        rset[1][1] = win_row[2];
        rset[1][2] = win_row[1];
        for (int rc = 0; rc < 2; rc++) begin
            for (int i = 0; i < 3; i++) begin
                sel[rc*2][i][0]   = item2_reg.xleft ? rset[rc][i][2] : rset[rc][i][0];
                sel[rc*2][i][1]   = rset[rc][i][1];
                sel[rc*2][i][2]   = rset[rc][i][2];
                sel[rc*2+1][i][0] = rset[rc][i][1];
                sel[rc*2+1][i][1] = rset[rc][i][2];
                sel[rc*2+1][i][2] = rset[rc][i][1];
            end
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_kernel
        sobel_grad u_grad (
            .win (sel[k]),
            .gx  (gx_w[k]),
            .gy  (gy_w[k])
        );
        sobel_mag u_mag (
            .gx       (gx3_reg[k]),
            .gy       (gy3_reg[k]),
            .thr_sq   (thr_sq_reg),
            .edge_bit (bit_w[k])
        );
    end

    // Result list of one pixel, rows ascending, columns ascending within a row.
    assign x1_w = item3_reg.x0 + COORD_W'(1);
    assign y1_w = item3_reg.y0 + COORD_W'(1);

    always_comb begin
        if (item3_reg.xlast) begin
            ex_next   = '{item3_reg.x0, x1_w, item3_reg.x0, x1_w};
            ey_next   = '{item3_reg.y0, item3_reg.y0, y1_w, y1_w};
            eb_next   = '{bit_w[0], bit_w[1], bit_w[2], bit_w[3]};
            last_next = item3_reg.ylast ? 2'd3 : 2'd1;
        end else begin
            ex_next   = '{item3_reg.x0, item3_reg.x0, item3_reg.x0, item3_reg.x0};
            ey_next   = '{item3_reg.y0, y1_w, y1_w, y1_w};
            eb_next   = '{bit_w[0], bit_w[2], bit_w[2], bit_w[2]};
            last_next = item3_reg.ylast ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg  <= 1'b0;
            idx_reg <= '0;
        end else if (en4) begin
            v4_reg  <= v3_reg && item3_reg.res;
            idx_reg <= '0;
        end else if (m_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            ex_reg   <= ex_next;
            ey_reg   <= ey_next;
            eb_reg   <= eb_next;
            last_reg <= last_next;
        end
    end

    assign m_valid    = v4_reg;
    assign m_pixel_x  = ex_reg[idx_reg];
    assign m_pixel_y  = ey_reg[idx_reg];
    assign m_edge_bit = eb_reg[idx_reg];
    assign m_run_last = (idx_reg == last_reg);

endmodule

// File: tb/tb_sobel_edge_threshold.sv
`timescale 1ns / 100ps

module tb_sobel_edge_threshold;
    import sobel_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               edge_bit;
        logic               run_last;
    } edge_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_gray_level = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [COORD_W-1:0]   m_pixel_x;
    logic [COORD_W-1:0]   m_pixel_y;
    logic                 m_edge_bit;
    logic                 m_run_last;

    // Predictor state.
    logic [CFG_W-1:0] frame_width_reg = FRAME_RESET;
    logic [CFG_W-1:0] frame_height_reg = FRAME_RESET;
    logic [CFG_W-1:0] edge_threshold_reg = CFG_W'(THR_RESET);
    pix_t             prev_column[MAX_HEIGHT_DEF];
    pix_t             older_column[MAX_HEIGHT_DEF];
    pix_t             sobel_window[9];
    int               column_count = 0;
    int               row_count = 0;

    edge_result_t pending_edges[$];

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   mismatches = 0;
    int   pixels_sent = 0;
    int   results_checked = 0;
    int   edges_found = 0;
    int   register_writes = 0;
    pix_t last_gray = '0;

    sobel_edge_threshold i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_gray_level (s_gray_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_edge_bit   (m_edge_bit),
        .m_run_last   (m_run_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_sobel_edge_threshold: FAIL");
        $finish;
    end

    function automatic int frame_size(input logic [CFG_W-1:0] v, input int hi);
        if (v < 2) begin
            return 2;
        end
        if (int'(v) > hi) begin
            return hi;
        end
        return int'(v);
    endfunction

    function automatic int win_at(input int r, input int c);
        return int'(sobel_window[r * 3 + c]);
    endfunction

    function automatic logic edge_at(input int ra, input int rb, input int rc,
                                     input int ca, input int cb, input int cc);
        int gx;
        int gy;
        int lim;
        gx = win_at(ra, cc) + 2 * win_at(rb, cc) + win_at(rc, cc)
           - win_at(ra, ca) - 2 * win_at(rb, ca) - win_at(rc, ca);
        gy = win_at(rc, ca) + 2 * win_at(rc, cb) + win_at(rc, cc)
           - win_at(ra, ca) - 2 * win_at(ra, cb) - win_at(ra, cc);
        lim = int'(edge_threshold_reg) + 1;
        return (gx * gx + gy * gy >= lim * lim);
    endfunction

    // Shifts one pixel into the column buffers and the window and queues the edge
    // bits that this pixel completes, in row-major order.
    function automatic void predict_edges(input pix_t gray);
        int           w;
        int           h;
        int           x;
        int           y;
        int           nr;
        int           nc;
        int           out_row[2];
        int           out_col[2];
        int           row_sel[2][3];
        int           col_sel[2][3];
        pix_t         a;
        pix_t         b;
        edge_result_t r;
        w = frame_size(frame_width_reg, MAX_WIDTH_DEF);
        h = frame_size(frame_height_reg, MAX_HEIGHT_DEF);
        x = column_count;
        y = row_count;
        a = older_column[y];
        b = prev_column[y];
        older_column[y] = b;
        prev_column[y] = gray;
        for (int i = 0; i < 6; i++) begin
            sobel_window[i] = sobel_window[i + 3];
        end
        sobel_window[6] = a;
        sobel_window[7] = b;
        sobel_window[8] = gray;
        if (x >= 1 && y >= 1) begin
            out_row[0] = y - 1;
            row_sel[0][0] = (y == 1) ? 2 : 0;
            row_sel[0][1] = 1;
            row_sel[0][2] = 2;
            nr = 1;
            if (y == h - 1) begin
                out_row[1] = y;
                row_sel[1][0] = 1;
                row_sel[1][1] = 2;
                row_sel[1][2] = 1;
                nr = 2;
            end
            out_col[0] = x - 1;
            col_sel[0][0] = (x == 1) ? 2 : 0;
            col_sel[0][1] = 1;
            col_sel[0][2] = 2;
            nc = 1;
            if (x == w - 1) begin
                out_col[1] = x;
                col_sel[1][0] = 1;
                col_sel[1][1] = 2;
                col_sel[1][2] = 1;
                nc = 2;
            end
            for (int ri = 0; ri < nr; ri++) begin
                for (int ci = 0; ci < nc; ci++) begin
                    r.pixel_x  = COORD_W'(out_col[ci]);
                    r.pixel_y  = COORD_W'(out_row[ri]);
                    r.edge_bit = edge_at(row_sel[ri][0], row_sel[ri][1], row_sel[ri][2],
                                         col_sel[ci][0], col_sel[ci][1], col_sel[ci][2]);
                    r.run_last = (ri == nr - 1) && (ci == nc - 1);
                    pending_edges.push_back(r);
                end
            end
        end
        row_count = y + 1;
        if (row_count >= h) begin
            row_count = 0;
            column_count = x + 1;
            if (column_count >= w) begin
                column_count = 0;
            end
        end
    endfunction

    function automatic pix_t rand_gray();
        case ($urandom_range(3))
            0: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            1: return last_gray;
            default: return pix_t'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_size();
        case ($urandom_range(9))
            0: return CFG_W'($urandom_range(1));
            1: return CFG_W'($urandom_range(2047, 10));
            default: return CFG_W'($urandom_range(9, 2));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_threshold();
        if ($urandom_range(7) == 0) begin
            return CFG_W'($urandom_range(2047));
        end
        return CFG_W'($urandom_range(600));
    endfunction

    always @(posedge aclk) begin
        edge_result_t got;
        edge_result_t want;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            got = {m_pixel_x, m_pixel_y, m_edge_bit, m_run_last};
            if (pending_edges.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result: x=%0d y=%0d edge=%0d last=%0d",
                             got.pixel_x, got.pixel_y, got.edge_bit, got.run_last);
                end
            end else begin
                want = pending_edges.pop_front();
                results_checked++;
                if (got.edge_bit === 1'b1) begin
                    edges_found++;
                end
                if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                    got.edge_bit !== want.edge_bit || got.run_last !== want.run_last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("Mismatch: expected x=%0d y=%0d edge=%0d last=%0d,",
                               want.pixel_x, want.pixel_y, want.edge_bit, want.run_last);
                        $display(" got x=%0d y=%0d edge=%0d last=%0d",
                                 got.pixel_x, got.pixel_y, got.edge_bit, got.run_last);
                    end
                end
            end
        end
    end

    task automatic send_pixel(input pix_t gray);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_gray_level <= gray;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_edges(gray);
        last_gray = gray;
        pixels_sent++;
    endtask

    task automatic drain_results(input int extra_cycles);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_edges.size() != 0) begin
            @(posedge aclk);
        end
        repeat (extra_cycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            REG_FRAME_WIDTH: begin
                frame_width_reg = value;
                column_count = 0;
                row_count = 0;
            end
            REG_FRAME_HEIGHT: begin
                frame_height_reg = value;
                column_count = 0;
                row_count = 0;
            end
            REG_EDGE_THRESHOLD: begin
                edge_threshold_reg = value;
            end
            default: begin
            end
        endcase
        register_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_threshold();
        pix_t frame[6] = '{8'd0, 8'd255, 8'd60, 8'd60, 8'd120, 8'd0};
        write_reg(REG_FRAME_WIDTH, CFG_W'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
        foreach (frame[i]) begin
            send_pixel(frame[i]);
        end
        drain_results(SETTLE_CYCLES);
    endtask

    task automatic test_clamped_sizes();
        pix_t frame[4] = '{8'd0, 8'd0, 8'd255, 8'd255};
        write_reg(REG_FRAME_WIDTH, CFG_W'(0));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
        write_reg(REG_EDGE_THRESHOLD, CFG_W'(0));
        foreach (frame[i]) begin
            send_pixel(frame[i]);
        end
        drain_results(SETTLE_CYCLES);
        write_reg(REG_EDGE_THRESHOLD, CFG_W'(2047));
        write_reg(REG_UNUSED, CFG_W'(5));
        foreach (frame[i]) begin
            send_pixel(frame[i] ^ 8'hFF);
        end
        drain_results(SETTLE_CYCLES);
    endtask

    // A horizontal ramp gives a gradient magnitude of exactly 400 in the middle column.
    task automatic test_threshold_boundary();
        pix_t frame[6] = '{8'd0, 8'd0, 8'd50, 8'd50, 8'd100, 8'd100};
        write_reg(REG_FRAME_WIDTH, CFG_W'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
        write_reg(REG_EDGE_THRESHOLD, CFG_W'(399));
        foreach (frame[i]) begin
            send_pixel(frame[i]);
        end
        drain_results(SETTLE_CYCLES);
        write_reg(REG_EDGE_THRESHOLD, CFG_W'(400));
        foreach (frame[i]) begin
            send_pixel(frame[i]);
        end
        drain_results(SETTLE_CYCLES);
    endtask

    task automatic test_threshold_midframe();
        write_reg(REG_FRAME_WIDTH, CFG_W'(5));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(4));
        write_reg(REG_EDGE_THRESHOLD, CFG_W'(1443));
        repeat (10) send_pixel(rand_gray());
        drain_results(SETTLE_CYCLES);
        write_reg(REG_EDGE_THRESHOLD, CFG_W'(40));
        repeat (10) send_pixel(rand_gray());
        drain_results(SETTLE_CYCLES);
    endtask

    task automatic test_largest_frames();
        send_idle_pct = 10;
        recv_stall_pct = 10;
        write_reg(REG_FRAME_WIDTH, CFG_W'(2047));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
        write_reg(REG_EDGE_THRESHOLD, CFG_W'(200));
        repeat (16) send_pixel(rand_gray());
        drain_results(SETTLE_CYCLES);
        write_reg(REG_FRAME_WIDTH, CFG_W'(2));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(1100));
        repeat (16) send_pixel(rand_gray());
        drain_results(SETTLE_CYCLES);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int num_pixels);
        int sent;
        int total;
        int count;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < num_pixels) begin
            drain_results(SETTLE_CYCLES);
            write_reg(REG_FRAME_WIDTH, rand_size());
            write_reg(REG_FRAME_HEIGHT, rand_size());
            write_reg(REG_EDGE_THRESHOLD, rand_threshold());
            total = frame_size(frame_width_reg, MAX_WIDTH_DEF) *
                    frame_size(frame_height_reg, MAX_HEIGHT_DEF);
            count = ($urandom_range(3) == 0) ? $urandom_range(total, 1) : total;
            if (count > 40) begin
                count = $urandom_range(40, 8);
            end
            if (count > num_pixels - sent) begin
                count = num_pixels - sent;
            end
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(29) == 0) begin
                    drain_results(0);
                end
                if ($urandom_range(39) == 0) begin
                    drain_results(SETTLE_CYCLES);
                    write_reg(REG_EDGE_THRESHOLD, rand_threshold());
                end
                send_pixel(rand_gray());
                sent++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_threshold();
        test_clamped_sizes();
        test_threshold_boundary();
        test_threshold_midframe();
        test_largest_frames();
        test_random_traffic(0, 0, 48);
        test_random_traffic(60, 0, 48);
        test_random_traffic(0, 60, 48);
        test_random_traffic(10, 10, 48);

        drain_results(20);
        $display("Covered %0d pixel transfers and %0d register writes over several frame sizes,",
                 pixels_sent, register_writes);
        $display("thresholds and idle patterns; %0d results checked, %0d of them edges.",
                 results_checked, edges_found);
        if (mismatches == 0) begin
            $display("tb_sobel_edge_threshold: PASS");
        end else begin
            $display("tb_sobel_edge_threshold: FAIL");
        end
        $finish;
    end

endmodule

// File: sobel_edge_threshold.f
sv/sobel_pkg.sv
sv/sobel_col_buf.sv
sv/sobel_row_cell.sv
sv/sobel_grad.sv
sv/sobel_mag.sv
sv/sobel_edge_threshold.sv
tb/tb_sobel_edge_threshold.sv
